### rtl/mts_pkg.sv
// Package for the multi-policy task selector: command and policy codes,
// controller state and scan mode types. No dependencies.
package mts_pkg;

  localparam logic [1:0] FUNC_SET     = 2'd0;
  localparam logic [1:0] FUNC_PICK    = 2'd1;
  localparam logic [1:0] FUNC_REBUILD = 2'd2;

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_RR   = 2'd1;
  localparam logic [1:0] POL_PRIO = 2'd2;

  localparam logic REG_POLICY = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIFO_POP,
    ST_PG_RQ,
    ST_PG_RS,
    ST_PG_CK,
    ST_SCAN
  } state_t;

  typedef enum logic [1:0] {
    SCAN_APPEND,
    SCAN_RR,
    SCAN_PRIO
  } scan_mode_t;

endpackage

### rtl/multi_policy_task_selector_top.sv
// Multi-policy task selector top: command decode, FIFO ready queue memory,
// scan sequencer and APB policy register. Uses mts_pkg and mts_slot_table.
//
//   channel   handshake            payload
//   input     start / busy         in_func, in_slot, in_ready_req, in_priority_req
//   result    out_strobe           out_found, out_chosen_slot, out_queue_overflow
//   config    psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// Set, unknown commands and picks that need no scan: result 1 cycle after accept.
// FIFO pick: one queue memory read (ST_FIFO_POP). Round robin and priority picks
// walk the slot table through its single read port, one slot per cycle. Rebuild
// drops queued entries whose slot is no longer ready, then appends each ready slot.
// Reset (rst_n low, synchronous) clears all control state and the slot table valid
// bits; no clearing pass. busy is high while a request is in progress; results
// cannot be held off and appear for exactly one cycle.
module multi_policy_task_selector_top #(
  parameter int SLOT_COUNT    = 64,
  parameter int QUEUE_DEPTH   = 64,
  parameter int PRIORITY_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [5:0]  in_slot,
  input  logic        in_ready_req,
  input  logic [7:0]  in_priority_req,
  output logic        out_strobe,
  output logic        out_found,
  output logic [5:0]  out_chosen_slot,
  output logic        out_queue_overflow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW  = $clog2(SLOT_COUNT);
  localparam int SIW = $clog2(SLOT_COUNT + 1);
  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int PB  = PRIORITY_BITS;

  function automatic logic [QAW-1:0] q_inc(input logic [QAW-1:0] p);
    q_inc = (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + QAW'(1);
  endfunction

  mts_pkg::state_t     state_r, state_nxt;
  mts_pkg::scan_mode_t mode_r, mode_nxt;

  logic [1:0]     policy_r;
  logic [SIW-1:0] scan_ptr_r, scan_ptr_nxt;
  logic [QAW-1:0] head_r, head_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic [QAW-1:0] rp_r, rp_nxt, wp_r, wp_nxt;
  logic [QCW-1:0] k_r, k_nxt, n_r, n_nxt;
  logic [SW-1:0]  ent_r, ent_nxt;
  logic [SIW-1:0] idx_r, idx_nxt;
  logic           chk_v_r, chk_v_nxt;
  logic [SW-1:0]  chk_idx_r, chk_idx_nxt;
  logic           best_v_r, best_v_nxt;
  logic [SW-1:0]  best_idx_r, best_idx_nxt;
  logic [PB-1:0]  best_prio_r, best_prio_nxt;
  logic           ovf_r, ovf_nxt;

  logic          out_strobe_r, out_strobe_nxt;
  logic          out_found_r, out_found_nxt;
  logic [SW-1:0] out_sel;
  logic          out_ovf_r, out_ovf_nxt;
  logic [5:0]    out_slot_r;
  logic [8:0]    out_sel_w;

  // Ready queue memory
  logic [SW-1:0]  qmem [QUEUE_DEPTH];
  logic           q_we;
  logic [QAW-1:0] q_waddr, q_raddr;
  logic [SW-1:0]  q_wdata, q_rdata_r;

  // Slot table ports
  logic          s_we;
  logic [SW-1:0] s_waddr, s_raddr;
  logic [PB-1:0] s_wprio;
  logic          s_rready;
  logic [PB-1:0] s_rprio;

  logic        accept;
  logic [8:0]  in_slot_w;
  logic [15:0] in_prio_w;
  logic        issue;
  logic        hit;
  logic        cfg_wr;

  assign busy      = (state_r != mts_pkg::ST_IDLE);
  assign accept    = start & ~busy;
  assign in_slot_w = 9'(in_slot);
  assign in_prio_w = 16'(in_priority_req);

  assign s_we    = accept && (in_func == mts_pkg::FUNC_SET) && (in_slot_w < 9'(SLOT_COUNT));
  assign s_waddr = in_slot_w[SW-1:0];
  assign s_wprio = in_prio_w[PB-1:0];

  mts_slot_table #(
    .SLOT_COUNT    (SLOT_COUNT),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_slot_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (s_we),
    .wr_addr  (s_waddr),
    .wr_ready (in_ready_req),
    .wr_prio  (s_wprio),
    .rd_addr  (s_raddr),
    .rd_ready (s_rready),
    .rd_prio  (s_rprio)
  );

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_waddr] <= q_wdata;
    end
    q_rdata_r <= qmem[q_raddr];
  end

  assign issue = (idx_r != SIW'(SLOT_COUNT));
  assign hit   = chk_v_r & s_rready;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    scan_ptr_nxt   = scan_ptr_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    k_nxt          = k_r;
    n_nxt          = n_r;
    ent_nxt        = ent_r;
    idx_nxt        = idx_r;
    chk_v_nxt      = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    best_v_nxt     = best_v_r;
    best_idx_nxt   = best_idx_r;
    best_prio_nxt  = best_prio_r;
    ovf_nxt        = ovf_r;
    out_strobe_nxt = 1'b0;
    out_found_nxt  = 1'b0;
    out_sel        = '0;
    out_ovf_nxt    = 1'b0;
    q_we           = 1'b0;
    q_waddr        = wp_r;
    q_wdata        = ent_r;
    q_raddr        = head_r;
    s_raddr        = '0;

    unique case (state_r)
      mts_pkg::ST_IDLE: begin
        if (accept) begin
          idx_nxt    = '0;
          best_v_nxt = 1'b0;
          best_idx_nxt = '0;
          unique case (in_func)
            mts_pkg::FUNC_PICK: begin
              unique case (policy_r)
                mts_pkg::POL_FIFO: begin
                  // head entry is being read this cycle
                  if (count_r == '0) begin
                    out_strobe_nxt = 1'b1;
                  end else begin
                    state_nxt = mts_pkg::ST_FIFO_POP;
                  end
                end
                mts_pkg::POL_RR: begin
                  idx_nxt   = scan_ptr_r;
                  mode_nxt  = mts_pkg::SCAN_RR;
                  state_nxt = mts_pkg::ST_SCAN;
                end
                mts_pkg::POL_PRIO: begin
                  mode_nxt  = mts_pkg::SCAN_PRIO;
                  state_nxt = mts_pkg::ST_SCAN;
                end
                default: begin
                  out_strobe_nxt = 1'b1;
                end
              endcase
            end
            mts_pkg::FUNC_REBUILD: begin
              // compact in place from the current head
              rp_nxt    = head_r;
              wp_nxt    = head_r;
              k_nxt     = '0;
              n_nxt     = '0;
              ovf_nxt   = 1'b0;
              state_nxt = mts_pkg::ST_PG_RQ;
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end

      mts_pkg::ST_FIFO_POP: begin
        out_strobe_nxt = 1'b1;
        out_found_nxt  = 1'b1;
        out_sel        = q_rdata_r;
        head_nxt       = q_inc(head_r);
        count_nxt      = count_r - QCW'(1);
        state_nxt      = mts_pkg::ST_IDLE;
      end

      mts_pkg::ST_PG_RQ: begin
        if (k_r == count_r) begin
          idx_nxt   = '0;
          mode_nxt  = mts_pkg::SCAN_APPEND;
          state_nxt = mts_pkg::ST_SCAN;
        end else begin
          q_raddr   = rp_r;
          rp_nxt    = q_inc(rp_r);
          state_nxt = mts_pkg::ST_PG_RS;
        end
      end

      mts_pkg::ST_PG_RS: begin
        s_raddr   = q_rdata_r;
        ent_nxt   = q_rdata_r;
        state_nxt = mts_pkg::ST_PG_CK;
      end

      mts_pkg::ST_PG_CK: begin
        // keep the entry only if its slot is still ready
        if (s_rready) begin
          q_we    = 1'b1;
          q_waddr = wp_r;
          q_wdata = ent_r;
          wp_nxt  = q_inc(wp_r);
          n_nxt   = n_r + QCW'(1);
        end
        k_nxt     = k_r + QCW'(1);
        state_nxt = mts_pkg::ST_PG_RQ;
      end

      mts_pkg::ST_SCAN: begin
        s_raddr     = idx_r[SW-1:0];
        chk_v_nxt   = issue;
        chk_idx_nxt = idx_r[SW-1:0];
        if (issue) begin
          idx_nxt = idx_r + SIW'(1);
        end
        unique case (mode_r)
          mts_pkg::SCAN_APPEND: begin
            if (hit) begin
              if (n_r != QCW'(QUEUE_DEPTH)) begin
                q_we    = 1'b1;
                q_waddr = wp_r;
                q_wdata = chk_idx_r;
                wp_nxt  = q_inc(wp_r);
                n_nxt   = n_r + QCW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            if (!issue && !chk_v_r) begin
              count_nxt      = n_r;
              out_strobe_nxt = 1'b1;
              out_ovf_nxt    = ovf_r;
              state_nxt      = mts_pkg::ST_IDLE;
            end
          end
          mts_pkg::SCAN_RR: begin
            if (hit) begin
              scan_ptr_nxt   = SIW'(chk_idx_r) + SIW'(1);
              out_strobe_nxt = 1'b1;
              out_found_nxt  = 1'b1;
              out_sel        = chk_idx_r;
              chk_v_nxt      = 1'b0;
              state_nxt      = mts_pkg::ST_IDLE;
            end else if (!issue && !chk_v_r) begin
              // ran off the end: rewind
              scan_ptr_nxt   = '0;
              out_strobe_nxt = 1'b1;
              state_nxt      = mts_pkg::ST_IDLE;
            end
          end
          default: begin
            if (hit && (!best_v_r || (s_rprio < best_prio_r))) begin
              best_v_nxt    = 1'b1;
              best_idx_nxt  = chk_idx_r;
              best_prio_nxt = s_rprio;
            end
            if (!issue && !chk_v_r) begin
              out_strobe_nxt = 1'b1;
              out_found_nxt  = best_v_r;
              out_sel        = best_idx_r;
              state_nxt      = mts_pkg::ST_IDLE;
            end
          end
        endcase
      end

      default: begin
        state_nxt = mts_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_sel_w = 9'(out_sel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mts_pkg::ST_IDLE;
      mode_r       <= mts_pkg::SCAN_APPEND;
      scan_ptr_r   <= '0;
      head_r       <= '0;
      count_r      <= '0;
      rp_r         <= '0;
      wp_r         <= '0;
      k_r          <= '0;
      n_r          <= '0;
      idx_r        <= '0;
      chk_v_r      <= 1'b0;
      best_v_r     <= 1'b0;
      ovf_r        <= 1'b0;
      out_strobe_r <= 1'b0;
      out_found_r  <= 1'b0;
      out_slot_r   <= '0;
      out_ovf_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      scan_ptr_r   <= scan_ptr_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      rp_r         <= rp_nxt;
      wp_r         <= wp_nxt;
      k_r          <= k_nxt;
      n_r          <= n_nxt;
      idx_r        <= idx_nxt;
      chk_v_r      <= chk_v_nxt;
      best_v_r     <= best_v_nxt;
      ovf_r        <= ovf_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_found_r  <= out_found_nxt;
      out_slot_r   <= out_sel_w[5:0];
      out_ovf_r    <= out_ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r       <= ent_nxt;
    chk_idx_r   <= chk_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_prio_r <= best_prio_nxt;
  end

  assign out_strobe         = out_strobe_r;
  assign out_found          = out_found_r;
  assign out_chosen_slot    = out_slot_r;
  assign out_queue_overflow = out_ovf_r;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= mts_pkg::POL_FIFO;
    end else if (cfg_wr && (paddr[2] == mts_pkg::REG_POLICY)) begin
      policy_r <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[2] == mts_pkg::REG_POLICY) ? 32'(policy_r) : '0;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QUEUE_DEPTH))
    else $error("ready queue count above depth");

  a_scan_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_ptr_r <= SIW'(SLOT_COUNT))
    else $error("round robin pointer past slot count");

  a_set_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_func == mts_pkg::FUNC_SET)) |=> (out_strobe && !out_found))
    else $error("set request without its result");

  a_found_xor_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_found_r && out_ovf_r))
    else $error("pick and overflow flagged together");

endmodule

### rtl/mts_slot_table.sv
// Slot table: ready flag and priority per task slot in one synchronous memory,
// with per-entry valid flops so the table reads as all zero after reset.
// Standalone; used by multi_policy_task_selector_top.
module mts_slot_table #(
  parameter int SLOT_COUNT    = 64,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
  input  logic                          wr_ready,
  input  logic [PRIORITY_BITS-1:0]      wr_prio,
  input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
  output logic                          rd_ready,
  output logic [PRIORITY_BITS-1:0]      rd_prio
);

  localparam int EW = PRIORITY_BITS + 1;

  logic [EW-1:0]         mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_r;
  logic [EW-1:0]         rdata_r;
  logic                  rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_ready, wr_prio};
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rvld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rvld_r <= valid_r[rd_addr];
    end
  end

  // An entry never written reads as not ready, priority zero.
  assign rd_ready = rvld_r & rdata_r[EW-1];
  assign rd_prio  = rvld_r ? rdata_r[PRIORITY_BITS-1:0] : '0;

endmodule
